// ===== hw/rtl/vts_pkg.sv =====
package vts_pkg;

  localparam int unsigned AXIS_MAX_DEF     = 16;
  localparam int unsigned VOXEL_DEPTH_DEF  = 4096;
  localparam int unsigned DENSITY_BITS_DEF = 16;

  localparam int unsigned SIZE_W    = 5;
  localparam int unsigned INDEX_W   = 12;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned POS_W     = 18;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned OUT_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned S_FIELDS_W = INDEX_W + VALUE_W + 3 * POS_W;
  localparam int unsigned S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

  localparam int unsigned SCALED_W = POS_W + SIZE_W + 1;
  localparam int unsigned CELL_W   = SCALED_W - FRAC_W;
  localparam int unsigned COORD_W  = CELL_W + 1;
  localparam int unsigned AREA_W   = 2 * SIZE_W;
  localparam int unsigned TMP_W    = CELL_W + SIZE_W + 2;
  localparam int unsigned BASE_W   = TMP_W + SIZE_W + 2;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned NUM_CORNERS = 8;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned BLEND_STEPS = 7;
  localparam int unsigned X_STEPS     = 4;
  localparam int unsigned XY_STEPS    = 6;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = CFG_IDX_W'(2);

  typedef struct packed {
    logic [SIZE_W-1:0] nx;
    logic [SIZE_W-1:0] ny;
    logic [SIZE_W-1:0] nz;
    logic [AREA_W-1:0] nxny;
  } grid_t;

  typedef struct packed {
    logic                     is_query;
    logic [INDEX_W-1:0]       index;
    logic [VALUE_W-1:0]       value;
    logic signed [CELL_W-1:0] cx;
    logic signed [CELL_W-1:0] cy;
    logic signed [CELL_W-1:0] cz;
    logic [FRAC_W-1:0]        fx;
    logic [FRAC_W-1:0]        fy;
    logic [FRAC_W-1:0]        fz;
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE0,
    ST_BASE1,
    ST_READ,
    ST_DRAIN,
    ST_BLEND
  } back_state_e;

  function automatic logic [SIZE_W-1:0] eff_size(logic [SIZE_W-1:0] s, int unsigned amax);
    logic [SIZE_W-1:0] r;
    r = s;
    if (int'(s) > amax) begin
      r = SIZE_W'(amax);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/vts_ram.sv =====
module vts_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/vts_fifo.sv =====
module vts_fifo
  import vts_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  op_t  push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output op_t  pop_data_o
);

  op_t               mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/vts_front.sv =====
module vts_front
  import vts_pkg::*;
(
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  input  logic                 s_axis_tuser_i,
  input  grid_t                grid_i,
  output logic                 op_valid_o,
  input  logic                 op_ready_i,
  output op_t                  op_o
);

  logic signed [POS_W-1:0]    pos_x, pos_y, pos_z;
  logic signed [SCALED_W-1:0] sx, sy, sz;

  assign pos_x = $signed(s_axis_tdata_i[INDEX_W+VALUE_W +: POS_W]);
  assign pos_y = $signed(s_axis_tdata_i[INDEX_W+VALUE_W+POS_W +: POS_W]);
  assign pos_z = $signed(s_axis_tdata_i[INDEX_W+VALUE_W+2*POS_W +: POS_W]);

  // scale by axis size, floor split into cell and fraction
  assign sx = pos_x * $signed({1'b0, grid_i.nx});
  assign sy = pos_y * $signed({1'b0, grid_i.ny});
  assign sz = pos_z * $signed({1'b0, grid_i.nz});

  always_comb begin
    op_o.is_query = (s_axis_tuser_i == CMD_QUERY);
    op_o.index    = s_axis_tdata_i[INDEX_W-1:0];
    op_o.value    = s_axis_tdata_i[INDEX_W +: VALUE_W];
    op_o.cx       = sx[SCALED_W-1:FRAC_W];
    op_o.cy       = sy[SCALED_W-1:FRAC_W];
    op_o.cz       = sz[SCALED_W-1:FRAC_W];
    op_o.fx       = sx[FRAC_W-1:0];
    op_o.fy       = sy[FRAC_W-1:0];
    op_o.fz       = sz[FRAC_W-1:0];
  end

  assign op_valid_o      = s_axis_tvalid_i;
  assign s_axis_tready_o = op_ready_i;

endmodule

// ===== hw/rtl/vts_back.sv =====
module vts_back
  import vts_pkg::*;
#(
  parameter int unsigned VOXEL_DEPTH  = VOXEL_DEPTH_DEF,
  parameter int unsigned DENSITY_BITS = DENSITY_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  grid_t            grid_i,
  input  logic             op_valid_i,
  output logic             op_ready_o,
  input  op_t              op_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [OUT_W-1:0] m_axis_tdata_o
);

  localparam int unsigned AW = $clog2(VOXEL_DEPTH);
  localparam int unsigned DW = DENSITY_BITS;
  localparam int unsigned PW = DW + FRAC_W + 2;

  back_state_e state_q, state_d;

  logic [CNT_W-1:0]         cnt_q;
  op_t                      op_q;
  logic signed [TMP_W-1:0]  tmp_q;
  logic signed [BASE_W-1:0] base_q;
  logic                     iss_q, cv_q;
  logic [DW-1:0]            w_q [NUM_CORNERS];
  logic                     out_valid_q;
  logic [OUT_W-1:0]         out_data_q;

  logic                     pop, out_free, last_blend;
  logic                     ram_en, ram_we;
  logic [AW-1:0]            ram_addr;
  logic [DW-1:0]            ram_wdata, ram_rdata;

  logic [31:0]              wr_wide, rd_wide, val_wide, res_wide;
  logic                     dx, dy, dz;
  logic signed [COORD_W-1:0] xc, yc, zc;
  logic                     in_grid;
  logic [BASE_W-1:0]        caddr;
  logic                     cvalid;
  logic signed [TMP_W-1:0]  tmp_d;
  logic signed [BASE_W-1:0] base_d;

  logic [FRAC_W-1:0]        frac;
  logic signed [DW:0]       diff;
  logic signed [PW-1:0]     prod;
  logic [PW-1:0]            sum;
  logic [DW-1:0]            blend_res;

  vts_ram #(
    .WIDTH (DW),
    .DEPTH (VOXEL_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign out_free   = !out_valid_q || m_axis_tready_i;
  assign last_blend = (cnt_q == CNT_W'(BLEND_STEPS - 1));

  // address of cell origin
  assign tmp_d  = op_q.cz * $signed({1'b0, grid_i.ny}) + op_q.cy;
  assign base_d = tmp_q * $signed({1'b0, grid_i.nx}) + op_q.cx;

  // corner address, one corner per cycle
  assign dx = cnt_q[0];
  assign dy = cnt_q[1];
  assign dz = cnt_q[2];
  assign xc = op_q.cx + $signed({1'b0, dx});
  assign yc = op_q.cy + $signed({1'b0, dy});
  assign zc = op_q.cz + $signed({1'b0, dz});
  assign in_grid = (xc >= 0) && (xc < $signed({{(COORD_W-SIZE_W){1'b0}}, grid_i.nx})) &&
                   (yc >= 0) && (yc < $signed({{(COORD_W-SIZE_W){1'b0}}, grid_i.ny})) &&
                   (zc >= 0) && (zc < $signed({{(COORD_W-SIZE_W){1'b0}}, grid_i.nz}));
  assign caddr = base_q + BASE_W'(dx)
               + (dy ? BASE_W'(grid_i.nx) : '0)
               + (dz ? BASE_W'(grid_i.nxny) : '0);
  assign cvalid  = in_grid && (caddr < VOXEL_DEPTH);
  assign rd_wide = 32'(caddr);
  assign wr_wide = 32'(op_i.index);
  assign val_wide = 32'(op_i.value);

  // one shared blend unit: a + ((b - a) * f) >> 16
  always_comb begin
    if (cnt_q < CNT_W'(X_STEPS)) begin
      frac = op_q.fx;
    end else if (cnt_q < CNT_W'(XY_STEPS)) begin
      frac = op_q.fy;
    end else begin
      frac = op_q.fz;
    end
  end
  assign diff      = $signed({1'b0, w_q[1]}) - $signed({1'b0, w_q[0]});
  assign prod      = diff * $signed({1'b0, frac});
  assign sum       = PW'(w_q[0]) + PW'(prod >>> FRAC_W);
  assign blend_res = sum[DW-1:0];
  assign res_wide  = 32'(blend_res);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (op_valid_i && op_i.is_query) begin
          state_d = ST_BASE0;
        end
      end
      ST_BASE0: state_d = ST_BASE1;
      ST_BASE1: state_d = ST_READ;
      ST_READ: begin
        if (cnt_q == CNT_W'(NUM_CORNERS - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_BLEND;
      ST_BLEND: begin
        if (last_blend && out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    op_ready_o = 1'b0;
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = rd_wide[AW-1:0];
    ram_wdata  = val_wide[DW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        op_ready_o = 1'b1;
        if (op_valid_i && !op_i.is_query) begin
          ram_addr = wr_wide[AW-1:0];
          ram_en   = (wr_wide < VOXEL_DEPTH);
          ram_we   = 1'b1;
        end
      end
      ST_READ: ram_en = 1'b1;
      default: ;
    endcase
  end

  assign pop = op_valid_i && op_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      iss_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      iss_q   <= (state_q == ST_READ);
      if (state_q == ST_READ || (state_q == ST_BLEND && !last_blend)) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (state_q != ST_BLEND) begin
        cnt_q <= '0;
      end else if (out_free) begin
        cnt_q <= '0;
      end
      if (state_q == ST_BLEND && last_blend && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      op_q <= op_i;
    end
    if (state_q == ST_BASE0) begin
      tmp_q <= tmp_d;
    end
    if (state_q == ST_BASE1) begin
      base_q <= base_d;
    end
    cv_q <= cvalid;
    if (iss_q) begin
      for (int i = 0; i < NUM_CORNERS - 1; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[NUM_CORNERS-1] <= cv_q ? ram_rdata : '0;
    end else if (state_q == ST_BLEND && !last_blend) begin
      for (int i = 0; i < NUM_CORNERS - 2; i++) begin
        w_q[i] <= w_q[i+2];
      end
      w_q[CNT_W'(BLEND_STEPS - 1) - cnt_q] <= blend_res;
    end
    if (state_q == ST_BLEND && last_blend && out_free) begin
      out_data_q <= res_wide[OUT_W-1:0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ===== hw/rtl/voxel_trilinear_sample_top.sv =====
// channel  | dir | handshake                      | payload
// s_axis   | in  | s_axis_tvalid_i/s_axis_tready_o | tdata, tuser = command
// m_axis   | out | m_axis_tvalid_o/m_axis_tready_i | tdata = density_out
// cfg      | in  | cfg_we_i                        | cfg_idx_i, cfg_data_i
//
// a write beat is done by the back end in its idle state; a query runs through ST_BASE0 and
// ST_BASE1 for the cell address, 8 corner reads from the single-port voxel ram,
// ST_DRAIN for the read latency, 7 blend steps through one shared multiplier
// a two-entry queue lets the front take beats while the back end is busy
// reset clears control and sizes (16 each); voxel ram holds garbage until written
// a stalled result holds only the last blend step, the queue keeps filling until full
module voxel_trilinear_sample_top
  import vts_pkg::*;
#(
  parameter int unsigned AXIS_MAX     = AXIS_MAX_DEF,
  parameter int unsigned VOXEL_DEPTH  = VOXEL_DEPTH_DEF,
  parameter int unsigned DENSITY_BITS = DENSITY_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // voxel_index, voxel_value, pos_x, pos_y, pos_z, zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // command
  input  logic                 s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // density_out
  output logic [OUT_W-1:0]     m_axis_tdata_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SIZE_W-1:0]    cfg_data_i
);

  logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
  grid_t             grid;
  logic              f_valid, f_ready, b_valid, b_ready;
  op_t               f_op, b_op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SIZE_RESET;
      size_y_q <= SIZE_RESET;
      size_z_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SIZE_X: size_x_q <= cfg_data_i;
        CFG_SIZE_Y: size_y_q <= cfg_data_i;
        CFG_SIZE_Z: size_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    grid.nx   = eff_size(size_x_q, AXIS_MAX);
    grid.ny   = eff_size(size_y_q, AXIS_MAX);
    grid.nz   = eff_size(size_z_q, AXIS_MAX);
    grid.nxny = grid.nx * grid.ny;
  end

  vts_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .grid_i          (grid),
    .op_valid_o      (f_valid),
    .op_ready_i      (f_ready),
    .op_o            (f_op)
  );

  vts_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_op),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_op)
  );

  vts_back #(
    .VOXEL_DEPTH  (VOXEL_DEPTH),
    .DENSITY_BITS (DENSITY_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .grid_i          (grid),
    .op_valid_i      (b_valid),
    .op_ready_o      (b_ready),
    .op_i            (b_op),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

// ===== bench/vts_density_checker.sv =====
`timescale 1ns / 1ps

module vts_density_checker
  import vts_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  input  logic                 s_axis_tready_i,
  // voxel_index, voxel_value, pos_x, pos_y, pos_z, zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // command
  input  logic                 s_axis_tuser_i,
  input  logic                 m_axis_tvalid_i,
  input  logic                 m_axis_tready_i,
  // density_out
  input  logic [OUT_W-1:0]     m_axis_tdata_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SIZE_W-1:0]    cfg_data_i,
  output int unsigned          mismatch_cnt_o,
  output int unsigned          pending_o
);

  logic [VALUE_W-1:0] voxel_mem [VOXEL_DEPTH_DEF];
  logic [SIZE_W-1:0]  grid_n [3];
  logic [OUT_W-1:0]   pending_density_q [$];
  int unsigned        mismatch_cnt;

  function automatic longint axis_len(logic [SIZE_W-1:0] s);
    if (s > AXIS_MAX_DEF) begin
      return AXIS_MAX_DEF;
    end
    return longint'(s);
  endfunction

  // corners off the grid read as zero
  function automatic longint voxel_at(longint x, longint y, longint z,
                                      longint nx, longint ny, longint nz);
    if (x < 0 || x >= nx || y < 0 || y >= ny || z < 0 || z >= nz) begin
      return 0;
    end
    return longint'(voxel_mem[(z * ny + y) * nx + x]);
  endfunction

  function automatic longint lerp16(longint f, longint a, longint b);
    return (a * (longint'(1) << FRAC_W) - a * f + b * f) >> FRAC_W;
  endfunction

  function automatic logic [OUT_W-1:0] interp_density(logic [S_TDATA_W-1:0] beat);
    longint                   n [3];
    longint                   cell_idx [3];
    longint                   frac [3];
    longint                   c [2][2][2];
    longint                   s;
    longint                   d00, d01, d10, d11, d0, d1, r;
    logic signed [POS_W-1:0]  p;
    int                       a, dx, dy, dz;
    for (a = 0; a < 3; a++) begin
      n[a]        = axis_len(grid_n[a]);
      p           = beat[INDEX_W + VALUE_W + POS_W * a +: POS_W];
      s           = longint'(p) * n[a];
      cell_idx[a] = s >>> FRAC_W;
      frac[a]     = s & ((longint'(1) << FRAC_W) - 1);
    end
    for (dz = 0; dz < 2; dz++) begin
      for (dy = 0; dy < 2; dy++) begin
        for (dx = 0; dx < 2; dx++) begin
          c[dz][dy][dx] = voxel_at(cell_idx[0] + dx, cell_idx[1] + dy, cell_idx[2] + dz,
                                   n[0], n[1], n[2]);
        end
      end
    end
    // x first, then y, then z
    d00 = lerp16(frac[0], c[0][0][0], c[0][0][1]);
    d01 = lerp16(frac[0], c[1][0][0], c[1][0][1]);
    d10 = lerp16(frac[0], c[0][1][0], c[0][1][1]);
    d11 = lerp16(frac[0], c[1][1][0], c[1][1][1]);
    d0  = lerp16(frac[1], d00, d10);
    d1  = lerp16(frac[1], d01, d11);
    r   = lerp16(frac[2], d0, d1);
    return r[OUT_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [OUT_W-1:0] want;
    if (!rst_ni) begin
      grid_n = '{SIZE_RESET, SIZE_RESET, SIZE_RESET};
      pending_density_q.delete();
      mismatch_cnt = 0;
      mismatch_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SIZE_X: grid_n[0] = cfg_data_i;
          CFG_SIZE_Y: grid_n[1] = cfg_data_i;
          CFG_SIZE_Z: grid_n[2] = cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (pending_density_q.size() == 0) begin
          if (mismatch_cnt < 10) begin
            $display("%0t: density beat %h with no query waiting", $realtime, m_axis_tdata_i);
          end
          mismatch_cnt++;
        end else begin
          want = pending_density_q.pop_front();
          if (m_axis_tdata_i !== want) begin
            if (mismatch_cnt < 10) begin
              $display("%0t: density_out expected %h got %h", $realtime, want,
                       m_axis_tdata_i);
            end
            mismatch_cnt++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (s_axis_tuser_i == CMD_QUERY) begin
          pending_density_q.push_back(interp_density(s_axis_tdata_i));
        end else begin
          voxel_mem[s_axis_tdata_i[INDEX_W-1:0]] = s_axis_tdata_i[INDEX_W +: VALUE_W];
        end
      end
      mismatch_cnt_o <= mismatch_cnt;
      pending_o <= pending_density_q.size();
    end
  end

endmodule

// ===== bench/tb_voxel_trilinear_sample_top.sv =====
`timescale 1ns / 1ps

module tb_voxel_trilinear_sample_top;
  import vts_pkg::*;

  localparam int unsigned RAND_AXIS   = 32;
  localparam int unsigned DRAIN_WAIT  = 64;
  localparam int unsigned PHASE_ITEMS = 50;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i;
  logic                 s_axis_tuser_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [OUT_W-1:0]     m_axis_tdata_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [SIZE_W-1:0]    cfg_data_i;

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned beat_cnt;
  bit          voxel_written [VOXEL_DEPTH_DEF];
  logic [SIZE_W-1:0] grid_n [3];

  voxel_trilinear_sample_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  vts_density_checker density_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .mismatch_cnt_o  (mismatch_cnt),
    .pending_o       (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [VALUE_W-1:0] rand_density();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [POS_W-1:0] rand_pos();
    case ($urandom_range(9))
      0, 1: return POS_W'($urandom);
      2: begin
        case ($urandom_range(3))
          0: return '0;
          1: return POS_W'(65535);
          2: return POS_W'(65536);
          default: return '1;
        endcase
      end
      default: return POS_W'($urandom_range(65535));
    endcase
  endfunction

  task automatic send_beat(logic cmd, logic [INDEX_W-1:0] idx, logic [VALUE_W-1:0] val,
                           logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
                           logic signed [POS_W-1:0] pz);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= S_TDATA_W'({pz, py, px, val, idx});
    do @(posedge clk_i); while (!s_axis_tready_o);
    beat_cnt++;
    if (cmd == CMD_WRITE) begin
      voxel_written[idx] = 1'b1;
    end
  endtask

  task automatic store_voxel(logic [INDEX_W-1:0] idx, logic [VALUE_W-1:0] val);
    send_beat(CMD_WRITE, idx, val, rand_pos(), rand_pos(), rand_pos());
  endtask

  // in-grid corners that were never written get a value first
  task automatic sample_at(logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
                           logic signed [POS_W-1:0] pz);
    logic signed [POS_W-1:0] p [3];
    longint                  n [3];
    longint                  cell_idx [3];
    longint                  x, y, z;
    int                      a, dx, dy, dz;
    p = '{px, py, pz};
    for (a = 0; a < 3; a++) begin
      n[a]        = (grid_n[a] > AXIS_MAX_DEF) ? longint'(AXIS_MAX_DEF) : longint'(grid_n[a]);
      cell_idx[a] = (longint'(p[a]) * n[a]) >>> FRAC_W;
    end
    for (dz = 0; dz < 2; dz++) begin
      for (dy = 0; dy < 2; dy++) begin
        for (dx = 0; dx < 2; dx++) begin
          x = cell_idx[0] + dx;
          y = cell_idx[1] + dy;
          z = cell_idx[2] + dz;
          if (x >= 0 && x < n[0] && y >= 0 && y < n[1] && z >= 0 && z < n[2]) begin
            if (!voxel_written[(z * n[1] + y) * n[0] + x]) begin
              store_voxel(INDEX_W'((z * n[1] + y) * n[0] + x), rand_density());
            end
          end
        end
      end
    end
    send_beat(CMD_QUERY, INDEX_W'($urandom), VALUE_W'($urandom), px, py, pz);
  endtask

  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic program_grid(int unsigned sx, int unsigned sy, int unsigned sz);
    logic [CFG_IDX_W-1:0] reg_sel [3];
    int unsigned          want [3];
    int                   a;
    reg_sel = '{CFG_SIZE_X, CFG_SIZE_Y, CFG_SIZE_Z};
    want    = '{sx, sy, sz};
    settle();
    for (a = 0; a < 3; a++) begin
      if (want[a] == RAND_AXIS) begin
        want[a] = $urandom_range(1, AXIS_MAX_DEF);
      end
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= reg_sel[a];
      cfg_data_i <= SIZE_W'(want[a]);
      grid_n[a] = SIZE_W'(want[a]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // count covers the corner writes that a query brings along
  task automatic random_items(int unsigned count);
    int unsigned stop_at;
    stop_at = beat_cnt + count;
    while (beat_cnt < stop_at) begin
      if ($urandom_range(99) < 30) begin
        store_voxel(INDEX_W'($urandom_range(VOXEL_DEPTH_DEF - 1)), rand_density());
      end else begin
        sample_at(rand_pos(), rand_pos(), rand_pos());
      end
    end
  endtask

  initial begin
    int unsigned size_plan [9][3];
    int unsigned send_plan [3];
    int unsigned recv_plan [3];
    int          mode, ph;
    size_plan = '{'{1, 1, 1}, '{0, 7, 3}, '{31, 17, 20},
                  '{2, 3, 4}, '{16, 1, 9}, '{RAND_AXIS, RAND_AXIS, RAND_AXIS},
                  '{16, 16, 16}, '{RAND_AXIS, RAND_AXIS, RAND_AXIS}, '{5, 16, 2}};
    send_plan = '{17, 75, 0};
    recv_plan = '{75, 17, 0};
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = CMD_WRITE;
    m_axis_tready_i = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_SIZE_X;
    cfg_data_i      = '0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    beat_cnt        = 0;
    grid_n          = '{SIZE_RESET, SIZE_RESET, SIZE_RESET};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset sizes: extremes of values and positions
    store_voxel('0, '1);
    store_voxel('1, '1);
    store_voxel(INDEX_W'(1), '0);
    store_voxel(INDEX_W'(16), VALUE_W'(16'h8000));
    store_voxel(INDEX_W'(256), VALUE_W'(16'h1234));
    sample_at('0, '0, '0);
    sample_at(POS_W'(2048), POS_W'(2048), POS_W'(2048));
    sample_at(POS_W'(65535), POS_W'(65535), POS_W'(65535));
    sample_at(POS_W'(65536), '0, '0);
    sample_at('1, '1, '1);
    sample_at(POS_W'(131071), POS_W'(131071), POS_W'(131071));
    sample_at(POS_W'(-131072), POS_W'(-131072), POS_W'(-131072));
    sample_at(POS_W'(32768), POS_W'(4096), POS_W'(61440));
    store_voxel('0, '0);
    sample_at('0, POS_W'(1), POS_W'(-4095));

    for (mode = 0; mode < 3; mode++) begin
      for (ph = 0; ph < 3; ph++) begin
        program_grid(size_plan[mode * 3 + ph][0], size_plan[mode * 3 + ph][1],
                     size_plan[mode * 3 + ph][2]);
        send_idle_pct = send_plan[mode];
        recv_idle_pct = recv_plan[mode];
        random_items(PHASE_ITEMS);
      end
    end

    settle();
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
